### rtl/srpc_pkg.sv
package srpc_pkg;

    // Field widths
    localparam int CFG_W     = 13;
    localparam int POT_W     = 10;
    localparam int OPC_W     = 3;
    localparam int WIDTH_W   = 14;
    localparam int PROD_W    = POT_W + CFG_W;
    localparam int MODE_W    = 2;
    localparam int CNT_OUT_W = 6;
    localparam int POS_OUT_W = 5;
    localparam int QUOT_W    = 13;

    // Reset values and scale
    localparam logic [CFG_W-1:0]   BASE_RESET     = 13'd1953;
    localparam logic [CFG_W-1:0]   SPAN_RESET     = 13'd1683;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 14'd3000;
    localparam logic [POT_W:0]     ADC_FULL_SCALE = 11'd1023;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

    // Register index, taken from paddr[2]
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_SPAN = 1'b1;

    // Operation after classification
    typedef enum logic [2:0] {
        OP_SAMPLE = 3'd0,
        OP_RECORD = 3'd1,
        OP_SAVE   = 3'd2,
        OP_PLAY   = 3'd3,
        OP_STOP   = 3'd4,
        OP_TICK   = 3'd5,
        OP_NOP    = 3'd6
    } op_t;

    // Controller mode
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_RECORD = 3'b010,
        MODE_PLAY   = 3'b100
    } mode_t;

    // Mode as reported on the result
    localparam logic [MODE_W-1:0] MODE_CODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_PLAY   = 2'd2;

    // One classified item in the queue
    typedef struct packed {
        op_t               op;
        logic [PROD_W-1:0] product;
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### rtl/srpc_front.sv
module srpc_front
(
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,    // [9:0] pot_sample
    input  logic [srpc_pkg::OPC_W-1:0]    s_tuser,    // [2:0] opcode
    input  logic [srpc_pkg::CFG_W-1:0]    pulse_span,
    input  srpc_pkg::qstat_t              q_status,
    output logic                          push,
    output srpc_pkg::cmd_t                push_cmd
);

    logic [srpc_pkg::POT_W-1:0] pot;

    // Accept whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;
    assign pot      = s_tdata[srpc_pkg::POT_W-1:0];

    // Classify the opcode and scale the sample by the span
    always_comb
    begin
        unique case (s_tuser)
            srpc_pkg::OP_SAMPLE: push_cmd.op = srpc_pkg::OP_SAMPLE;
            srpc_pkg::OP_RECORD: push_cmd.op = srpc_pkg::OP_RECORD;
            srpc_pkg::OP_SAVE:   push_cmd.op = srpc_pkg::OP_SAVE;
            srpc_pkg::OP_PLAY:   push_cmd.op = srpc_pkg::OP_PLAY;
            srpc_pkg::OP_STOP:   push_cmd.op = srpc_pkg::OP_STOP;
            srpc_pkg::OP_TICK:   push_cmd.op = srpc_pkg::OP_TICK;
            default:             push_cmd.op = srpc_pkg::OP_NOP;
        endcase
        push_cmd.product = srpc_pkg::PROD_W'(pot) * srpc_pkg::PROD_W'(pulse_span);
    end

endmodule

### rtl/srpc_queue.sv
module srpc_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  srpc_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output srpc_pkg::cmd_t   pop_cmd,
    output srpc_pkg::qstat_t q_status
);

    localparam int PW = (srpc_pkg::QUEUE_DEPTH > 1) ? $clog2(srpc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(srpc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(srpc_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(srpc_pkg::QUEUE_DEPTH - 1);

    srpc_pkg::cmd_t slot_reg [srpc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_next;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/srpc_back.sv
module srpc_back
#(
    parameter int MAX_STEPS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [srpc_pkg::CFG_W-1:0]   pulse_base,
    input  srpc_pkg::qstat_t             q_status,
    input  srpc_pkg::cmd_t               pop_cmd,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata
);

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STEPS);
    localparam int WW = srpc_pkg::WIDTH_W;

    // Execute stage state
    srpc_pkg::mode_t mode_reg;
    srpc_pkg::mode_t mode_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [IW-1:0]   index_reg;
    logic [IW-1:0]   index_next;
    logic [CW-1:0]   step;
    logic            adv;
    logic            exec;
    logic            load;
    logic            sample;
    logic            save;
    logic [IW-1:0]   rd_addr;

    // Sample scaling
    logic [srpc_pkg::QUOT_W-1:0] hi_part;
    logic [WW-1:0]               fold1;
    logic [srpc_pkg::POT_W:0]    fold2;
    logic                        carry;
    logic [WW-1:0]               quot;
    logic [WW-1:0]               sample_width;

    // Resolve stage
    logic            s2_valid_reg;
    logic            s2_load_reg;
    logic            s2_sample_reg;
    logic            s2_save_reg;
    logic [WW-1:0]   s2_width_reg;
    logic [IW-1:0]   s2_addr_reg;
    srpc_pkg::mode_t s2_mode_reg;
    logic [CW-1:0]   s2_count_reg;
    logic [IW-1:0]   s2_index_reg;
    logic [WW-1:0]   width_reg;
    logic [WW-1:0]   width_next;
    logic [WW-1:0]   load_data;
    logic            wr_en;

    // Position store
    logic [WW-1:0]   store [MAX_STEPS];
    logic [WW-1:0]   rd_data_reg;
    logic            byp_hit_reg;
    logic [WW-1:0]   byp_data_reg;

    // Output register
    logic            m_tvalid_reg;
    logic [31:0]     m_tdata_reg;
    logic [srpc_pkg::MODE_W-1:0] mode_code;

    assign adv      = !m_tvalid_reg || m_tready;
    assign pop      = adv && !q_status.empty;
    assign exec     = pop;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Divide the product by 1023: x = 1024a + b gives x/1023 = a + (a+b)/1023, folded twice
    always_comb
    begin
        hi_part      = pop_cmd.product[srpc_pkg::PROD_W-1:srpc_pkg::POT_W];
        fold1        = WW'(hi_part) + WW'(pop_cmd.product[srpc_pkg::POT_W-1:0]);
        fold2        = (srpc_pkg::POT_W + 1)'(fold1[WW-1:srpc_pkg::POT_W])
                     + (srpc_pkg::POT_W + 1)'(fold1[srpc_pkg::POT_W-1:0]);
        carry        = (fold2 >= srpc_pkg::ADC_FULL_SCALE);
        quot         = WW'(hi_part) + WW'(fold1[WW-1:srpc_pkg::POT_W]) + WW'(carry);
        sample_width = WW'(pulse_base) + quot;
    end

    // Execute the mode, count and index updates of one item
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        index_next = index_reg;
        load       = 1'b0;
        sample     = 1'b0;
        save       = 1'b0;
        rd_addr    = '0;
        step       = CW'(index_reg) + 1'b1;
        if (exec)
        begin
            unique case (pop_cmd.op)
                srpc_pkg::OP_SAMPLE:
                begin
                    sample = (mode_reg != srpc_pkg::MODE_PLAY);
                end
                srpc_pkg::OP_RECORD:
                begin
                    if (mode_reg == srpc_pkg::MODE_RECORD)
                    begin
                        mode_next = srpc_pkg::MODE_NORMAL;
                    end
                    else if (mode_reg == srpc_pkg::MODE_NORMAL)
                    begin
                        mode_next  = srpc_pkg::MODE_RECORD;
                        count_next = '0;
                    end
                end
                srpc_pkg::OP_SAVE:
                begin
                    if (mode_reg == srpc_pkg::MODE_RECORD && count_reg < MAX_CNT)
                    begin
                        save       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                srpc_pkg::OP_PLAY:
                begin
                    if (mode_reg == srpc_pkg::MODE_PLAY)
                    begin
                        mode_next = srpc_pkg::MODE_NORMAL;
                    end
                    else if (count_reg != '0)
                    begin
                        mode_next  = srpc_pkg::MODE_PLAY;
                        index_next = '0;
                        load       = 1'b1;
                    end
                end
                srpc_pkg::OP_STOP:
                begin
                    mode_next  = srpc_pkg::MODE_NORMAL;
                    count_next = '0;
                    index_next = '0;
                end
                srpc_pkg::OP_TICK:
                begin
                    if (mode_reg == srpc_pkg::MODE_PLAY && count_reg != '0)
                    begin
                        index_next = (step >= count_reg) ? '0 : step[IW-1:0];
                        load       = 1'b1;
                        rd_addr    = index_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= srpc_pkg::MODE_NORMAL;
            count_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            index_reg <= index_next;
        end
    end

    // Hand the executed item to the resolve stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_load_reg   <= load;
            s2_sample_reg <= sample;
            s2_save_reg   <= save;
            s2_width_reg  <= sample_width;
            s2_addr_reg   <= count_reg[IW-1:0];
            s2_mode_reg   <= mode_next;
            s2_count_reg  <= count_next;
            s2_index_reg  <= index_next;
        end
    end

    // Write saves in the resolve stage; read for loads in the execute stage
    assign wr_en = adv && s2_valid_reg && s2_save_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_data_reg  <= store[rd_addr];
            byp_hit_reg  <= wr_en && (s2_addr_reg == rd_addr);
            byp_data_reg <= width_reg;
        end
        if (wr_en)
        begin
            store[s2_addr_reg] <= width_reg;
        end
    end

    // Resolve the width after this item
    always_comb
    begin
        load_data = byp_hit_reg ? byp_data_reg : rd_data_reg;
        if (s2_load_reg)
        begin
            width_next = load_data;
        end
        else if (s2_sample_reg)
        begin
            width_next = s2_width_reg;
        end
        else
        begin
            width_next = width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= srpc_pkg::WIDTH_RESET;
        end
        else if (adv && s2_valid_reg)
        begin
            width_reg <= width_next;
        end
    end

    // Encode the mode for the result
    always_comb
    begin
        unique case (s2_mode_reg)
            srpc_pkg::MODE_RECORD: mode_code = srpc_pkg::MODE_CODE_RECORD;
            srpc_pkg::MODE_PLAY:   mode_code = srpc_pkg::MODE_CODE_PLAY;
            default:               mode_code = srpc_pkg::MODE_CODE_NORMAL;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            m_tdata_reg <= {3'b000,
                            srpc_pkg::POS_OUT_W'(s2_index_reg),
                            srpc_pkg::CNT_OUT_W'(s2_count_reg),
                            (s2_mode_reg == srpc_pkg::MODE_PLAY),
                            (s2_mode_reg == srpc_pkg::MODE_RECORD),
                            mode_code,
                            width_next};
        end
    end

endmodule

### rtl/servo_record_playback_controller_unit.sv
// Teach-and-replay servo controller. Each input item is one event (opcode in s_tuser,
// potentiometer sample in s_tdata) and yields exactly one result item: the commanded pulse
// width, mode, LEDs, stored count and replay position after that event. Items are taken
// one per cycle and results leave one per cycle, in order, while the output is not stalled.
// An accepted item passes through a two-entry command queue (scaled sample and opcode), the
// execute stage (mode, count and index updates and the store read) and the resolve stage,
// which resolves the width into the output register. An output stall holds the back part;
// the queue then fills and drops s_tready, and once the output moves again the input stays
// held off until the full queue frees a slot. The position store is a MAX_STEPS-entry memory
// with a registered read port; it needs no clearing after reset, so items are accepted as
// soon as reset is released. pulse_base and pulse_span are written over the APB port; the
// user must write them only while idle, which the block itself does not enforce.
module servo_record_playback_controller_unit
#(
    parameter int MAX_STEPS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] pot_sample
    input  logic [2:0]  s_tuser,    // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [13:0] pulse_width, [15:14] mode_now, [16] record_led,
                                    // [17] play_led, [23:18] stored_count, [28:24] play_position
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [srpc_pkg::CFG_W-1:0] base_reg;
    logic [srpc_pkg::CFG_W-1:0] span_reg;
    logic                       cfg_write;
    logic                       push;
    logic                       pop;
    srpc_pkg::cmd_t             push_cmd;
    srpc_pkg::cmd_t             pop_cmd;
    srpc_pkg::qstat_t           q_status;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= srpc_pkg::BASE_RESET;
            span_reg <= srpc_pkg::SPAN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                srpc_pkg::REG_BASE: base_reg <= pwdata[srpc_pkg::CFG_W-1:0];
                srpc_pkg::REG_SPAN: span_reg <= pwdata[srpc_pkg::CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            srpc_pkg::REG_BASE: prdata = 32'(base_reg);
            srpc_pkg::REG_SPAN: prdata = 32'(span_reg);
            default:            prdata = '0;
        endcase
    end

    srpc_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pulse_span (span_reg),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    srpc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    srpc_back #(.MAX_STEPS(MAX_STEPS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse_base (base_reg),
        .q_status   (q_status),
        .pop_cmd    (pop_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    // A full queue must hold off the input side
    assert property (@(posedge clk) disable iff (!rst_n) q_status.full |-> !s_tready)
        else $error("input taken while command queue is full");

    // Record and playback never show together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("record and play LEDs both lit");

    // Play LED follows the reported mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17] == (m_tdata[15:14] == srpc_pkg::MODE_CODE_PLAY)))
        else $error("play LED disagrees with mode");

    // During replay the position stays inside the stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[17]) |-> ((MAX_STEPS > 32) || (m_tdata[28:24] < m_tdata[23:18])))
        else $error("replay position beyond stored count");
`endif

endmodule
